@@ design/hsvab_pkg.sv @@
// ----------------------------------------------------------------------------
// HSV adjust and blend package
// Shared payload types, register indexes and widths for the pixel pipeline.
// ----------------------------------------------------------------------------
package hsvab_pkg;

  localparam int ChannelBits = 16;
  localparam int DivStages   = ChannelBits + 1;

  typedef enum logic [1:0] {
    REG_HUE_OFFSET = 2'd0,
    REG_SAT_GAIN   = 2'd1,
    REG_VAL_GAIN   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [14:0] blend_factor;
    logic [15:0] in_red;
    logic [15:0] in_green;
    logic [15:0] in_blue;
    logic [15:0] in_alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
  } pixel_out_t;

  // Per-pixel context that travels alongside the divider.
  typedef struct packed {
    logic        bypass;
    logic [14:0] fac;
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic [15:0] a;
    logic [15:0] v;
    logic [15:0] hue_offset;
    logic [15:0] sat_gain;
    logic [15:0] val_gain;
  } ctx_t;

  // Signed floor((x + 2^(k-1)) / 2^k): an arithmetic shift floors already.
  function automatic logic signed [47:0] rnd14(input logic signed [47:0] x);
    logic signed [47:0] y;
    y = x + 48'sd8192;
    return y >>> 14;
  endfunction

  function automatic logic signed [47:0] rnd16(input logic signed [47:0] x);
    logic signed [47:0] y;
    y = x + 48'sd32768;
    return y >>> 16;
  endfunction

endpackage

@@ design/hsvab_div.sv @@
// ----------------------------------------------------------------------------
// HSV adjust and blend restoring divider
// Pipelined restoring divider, one quotient bit per stage, for s and h.
// ----------------------------------------------------------------------------
module hsvab_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 in_valid,
  input  logic [35:0]          s_num,
  input  logic [18:0]          s_den,
  input  logic [35:0]          h_num,
  input  logic [18:0]          h_den,
  input  hsvab_pkg::ctx_t      in_ctx,
  output logic                 out_valid,
  output logic [16:0]          s_quo,
  output logic [16:0]          h_quo,
  output hsvab_pkg::ctx_t      out_ctx
);

  localparam int N = hsvab_pkg::DivStages;

  logic [N:0]          vld;
  logic [35:0]         s_rem [N+1];
  logic [35:0]         h_rem [N+1];
  logic [18:0]         s_d   [N+1];
  logic [18:0]         h_d   [N+1];
  logic [16:0]         s_q   [N+1];
  logic [16:0]         h_q   [N+1];
  hsvab_pkg::ctx_t     ctx   [N+1];

  always_comb begin
    vld[0]   = in_valid;
    s_rem[0] = s_num;
    h_rem[0] = h_num;
    s_d[0]   = s_den;
    h_d[0]   = h_den;
    s_q[0]   = '0;
    h_q[0]   = '0;
    ctx[0]   = in_ctx;
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int Sh = N - 1 - k;
    logic [54:0] s_trial;
    logic [54:0] h_trial;
    assign s_trial = {19'd0, s_rem[k]} - ({36'd0, s_d[k]} << Sh);
    assign h_trial = {19'd0, h_rem[k]} - ({36'd0, h_d[k]} << Sh);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (advance) begin
        vld[k+1] <= vld[k];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        s_d[k+1] <= s_d[k];
        h_d[k+1] <= h_d[k];
        ctx[k+1] <= ctx[k];
        if (!s_trial[54]) begin
          s_rem[k+1] <= s_trial[35:0];
          s_q[k+1]   <= s_q[k] | (17'd1 << Sh);
        end else begin
          s_rem[k+1] <= s_rem[k];
          s_q[k+1]   <= s_q[k];
        end
        if (!h_trial[54]) begin
          h_rem[k+1] <= h_trial[35:0];
          h_q[k+1]   <= h_q[k] | (17'd1 << Sh);
        end else begin
          h_rem[k+1] <= h_rem[k];
          h_q[k+1]   <= h_q[k];
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign s_quo     = s_q[N];
  assign h_quo     = h_q[N];
  assign out_ctx   = ctx[N];

endmodule

@@ design/hsvab_rgb.sv @@
// ----------------------------------------------------------------------------
// HSV adjust and blend back-conversion and mix
// Gains, hue shift, HSV to RGB and the final blend over registered stages.
// ----------------------------------------------------------------------------
module hsvab_rgb (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  in_valid,
  input  logic [16:0]           s_in,
  input  logic [16:0]           h_in,
  input  hsvab_pkg::ctx_t       in_ctx,
  output logic                  out_valid,
  output hsvab_pkg::pixel_out_t out_pixel
);

  // Stage A: gains and hue shift.
  logic               va;
  hsvab_pkg::ctx_t    ca;
  logic signed [19:0] sp_a;
  logic signed [19:0] vp_a;
  logic [15:0]        h_a;

  // Stage B: sector and fraction, v'*s', s'*f, s'*(1-f).
  logic               vb;
  hsvab_pkg::ctx_t    cb;
  logic signed [19:0] vp_b;
  logic [2:0]         i_b;
  logic signed [47:0] vs_b;
  logic signed [19:0] sf_b;
  logic signed [19:0] sg_b;

  // Stage C: second products.
  logic               vc;
  hsvab_pkg::ctx_t    cc;
  logic signed [19:0] vp_c;
  logic [2:0]         i_c;
  logic signed [47:0] p_c;
  logic signed [47:0] vq_c;
  logic signed [47:0] vt_c;

  // Stage D: colour selection.
  logic               vd;
  hsvab_pkg::ctx_t    cd;
  logic signed [47:0] col_d [3];

  // Stage E: blend products.
  logic               ve;
  hsvab_pkg::ctx_t    ce;
  logic signed [47:0] mix_e [3];

  logic [16:0] off_sum;
  logic [18:0] h6;
  logic signed [47:0] q_w;
  logic signed [47:0] t_w;
  logic signed [47:0] col_w [3];
  logic [15:0] ch_w [3];
  logic signed [47:0] rs_w [3];

  assign off_sum = {1'b0, in_ctx.hue_offset} + 17'(h_in) + 17'h08000;
  assign h6      = 19'(h_a) * 19'd6;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else if (advance) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ca   <= in_ctx;
      sp_a <= 20'(hsvab_pkg::rnd14($signed({31'd0, s_in}) *
                                   $signed({32'd0, in_ctx.sat_gain})));
      vp_a <= 20'(hsvab_pkg::rnd14($signed({32'd0, in_ctx.v}) *
                                   $signed({32'd0, in_ctx.val_gain})));
      h_a  <= off_sum[15:0];

      cb   <= ca;
      vp_b <= vp_a;
      i_b  <= h6[18:16];
      vs_b <= vp_a * sp_a;
      sf_b <= 20'(hsvab_pkg::rnd16(sp_a * $signed({32'd0, h6[15:0]})));
      sg_b <= 20'(hsvab_pkg::rnd16(sp_a * $signed(48'd65536 - {32'd0, h6[15:0]})));

      cc   <= cb;
      vp_c <= vp_b;
      i_c  <= i_b;
      p_c  <= 48'(vp_b) - hsvab_pkg::rnd16(vs_b);
      vq_c <= vp_b * sf_b;
      vt_c <= vp_b * sg_b;

      cd    <= cc;
      col_d <= col_w;

      ce <= cd;
      for (int k = 0; k < 3; k++) begin
        mix_e[k] <= $signed(48'd16384 - {33'd0, cd.fac}) * $signed({32'd0, ch_w[k]})
                  + $signed({33'd0, cd.fac}) * col_d[k];
      end
    end
  end

  always_comb begin
    q_w = 48'(vp_c) - hsvab_pkg::rnd16(vq_c);
    t_w = 48'(vp_c) - hsvab_pkg::rnd16(vt_c);
    case (i_c)
      3'd0: begin
        col_w[0] = 48'(vp_c); col_w[1] = t_w;  col_w[2] = p_c;
      end
      3'd1: begin
        col_w[0] = q_w;  col_w[1] = 48'(vp_c); col_w[2] = p_c;
      end
      3'd2: begin
        col_w[0] = p_c;  col_w[1] = 48'(vp_c); col_w[2] = t_w;
      end
      3'd3: begin
        col_w[0] = p_c;  col_w[1] = q_w;  col_w[2] = 48'(vp_c);
      end
      3'd4: begin
        col_w[0] = t_w;  col_w[1] = p_c;  col_w[2] = 48'(vp_c);
      end
      default: begin
        col_w[0] = 48'(vp_c); col_w[1] = p_c;  col_w[2] = q_w;
      end
    endcase
    ch_w[0] = cd.r;
    ch_w[1] = cd.g;
    ch_w[2] = cd.b;
    for (int k = 0; k < 3; k++) begin
      rs_w[k] = hsvab_pkg::rnd14(mix_e[k]);
    end
  end

  function automatic logic [15:0] clamp(input logic signed [47:0] x);
    if (x < 0) begin
      return 16'd0;
    end else if (x > 48'sd65535) begin
      return 16'hFFFF;
    end
    return x[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pixel.out_alpha <= ce.a;
      if (ce.bypass) begin
        out_pixel.out_red   <= ce.r;
        out_pixel.out_green <= ce.g;
        out_pixel.out_blue  <= ce.b;
      end else begin
        out_pixel.out_red   <= clamp(rs_w[0]);
        out_pixel.out_green <= clamp(rs_w[1]);
        out_pixel.out_blue  <= clamp(rs_w[2]);
      end
    end
  end

endmodule

@@ design/hsv_adjust_blend_pixel_top.sv @@
// ----------------------------------------------------------------------------
// HSV adjust and blend pixel top level
// Each accepted input transaction passes through one input register, seventeen
// divider stages and six back-conversion stages on its way to the result.
// Throughput: one pixel per cycle; the pipeline advances whenever the output
// register is empty or its transaction is taken, and stall halts it whole.
// Reset clears all valid bits and loads the neutral register settings.
// ----------------------------------------------------------------------------
module hsv_adjust_blend_pixel_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hsvab_pkg::pixel_in_t  in_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hsvab_pkg::pixel_out_t out_pixel
);

  logic [15:0] hue_offset;
  logic [15:0] sat_gain;
  logic [15:0] val_gain;
  logic        advance;

  logic            v0;
  hsvab_pkg::ctx_t c0;
  logic [35:0]     s_num;
  logic [18:0]     s_den;
  logic [35:0]     h_num;
  logic [18:0]     h_den;

  logic            dv;
  logic [16:0]     s_quo;
  logic [16:0]     h_quo;
  hsvab_pkg::ctx_t dctx;

  logic [15:0] mx;
  logic [15:0] mn;
  logic [15:0] d;
  logic signed [19:0] n;
  logic signed [19:0] n_w;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_offset <= 16'd32768;
      sat_gain   <= 16'd16384;
      val_gain   <= 16'd16384;
    end else if (cfg_write) begin
      case (cfg_index)
        hsvab_pkg::REG_HUE_OFFSET: hue_offset <= cfg_data;
        hsvab_pkg::REG_SAT_GAIN:   sat_gain   <= cfg_data;
        hsvab_pkg::REG_VAL_GAIN:   val_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mx = in_pixel.in_red;
    mn = in_pixel.in_red;
    if (in_pixel.in_green > mx) mx = in_pixel.in_green;
    if (in_pixel.in_blue > mx) mx = in_pixel.in_blue;
    if (in_pixel.in_green < mn) mn = in_pixel.in_green;
    if (in_pixel.in_blue < mn) mn = in_pixel.in_blue;
    d = mx - mn;
    if (in_pixel.in_red == mx) begin
      n = $signed({4'd0, in_pixel.in_green}) - $signed({4'd0, in_pixel.in_blue});
    end else if (in_pixel.in_green == mx) begin
      n = $signed({3'd0, d, 1'b0}) + $signed({4'd0, in_pixel.in_blue})
        - $signed({4'd0, in_pixel.in_red});
    end else begin
      n = $signed({2'd0, d, 2'b0}) + $signed({4'd0, in_pixel.in_red})
        - $signed({4'd0, in_pixel.in_green});
    end
    n_w = (n < 0) ? n + $signed(20'(d) * 20'd6) : n;
  end

  // Stage 0 registers the dividend and divisor; a zero divisor is made safe
  // and the quotient ignored downstream through the zero terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (advance) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c0.bypass     <= (in_pixel.blend_factor == 15'd0) ||
                       (hue_offset == 16'd32768 && sat_gain == 16'd16384 &&
                        val_gain == 16'd16384);
      c0.fac        <= in_pixel.blend_factor;
      c0.r          <= in_pixel.in_red;
      c0.g          <= in_pixel.in_green;
      c0.b          <= in_pixel.in_blue;
      c0.a          <= in_pixel.in_alpha;
      c0.v          <= mx;
      c0.hue_offset <= hue_offset;
      c0.sat_gain   <= sat_gain;
      c0.val_gain   <= val_gain;
      s_num         <= (mx == 16'd0) ? 36'd0 : {4'd0, d, 16'd0};
      s_den         <= (mx == 16'd0) ? 19'd1 : {3'd0, mx};
      h_num         <= (d == 16'd0) ? 36'd0 : {n_w, 16'd0};
      h_den         <= (d == 16'd0) ? 19'd1 : 19'(d) * 19'd6;
    end
  end

  hsvab_div u_div (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (v0),
    .s_num    (s_num),
    .s_den    (s_den),
    .h_num    (h_num),
    .h_den    (h_den),
    .in_ctx   (c0),
    .out_valid(dv),
    .s_quo    (s_quo),
    .h_quo    (h_quo),
    .out_ctx  (dctx)
  );

  hsvab_rgb u_rgb (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (dv),
    .s_in     (s_quo),
    .h_in     (h_quo),
    .in_ctx   (dctx),
    .out_valid(out_valid),
    .out_pixel(out_pixel)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled although the output register is free.");

  a_output_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_pixel))
    else $error("Stalled output transaction changed.");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

endmodule
